@@ design/ssrm_pkg.sv @@
// Package: shared types, codes and frame constants of the serial switch register master.
`timescale 1ns / 1ps
package ssrm_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PREP    = 3'd1,
        PH_SHIFT   = 3'd2,
        PH_TRAIL   = 3'd3,
        PH_RELEASE = 3'd4,
        PH_PULSE   = 3'd5,
        PH_SAMPLE  = 3'd6,
        PH_CLOSE   = 3'd7
    } ssrm_phase_t;

    // Bit positions in the pin level vector
    localparam int PIN_CS    = 0;
    localparam int PIN_SK    = 1;
    localparam int PIN_DO    = 2;
    localparam int PIN_DOEN  = 3;
    localparam int PIN_CTLEN = 4;
    localparam int PIN_W     = 5;

    // Frame and clock counts
    localparam logic [5:0] READ_BITS    = 6'd46;
    localparam logic [5:0] WRITE_BITS   = 6'd27;
    localparam logic [5:0] SAMPLE_BITS  = 6'd32;
    localparam logic [5:0] EXTRA_CLOCKS = 6'd2;
    localparam int         FRAME_W      = 46;

    // Read preamble and opcode, write start and opcode
    localparam logic [31:0] READ_PREAMBLE = 32'hFFFF_FFFF;
    localparam logic [3:0]  READ_OPCODE   = 4'b0110;
    localparam logic [2:0]  WRITE_OPCODE  = 3'b101;

    // Reset value of the half period register
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd3;

    // Bit positions of result fields in the output tdata
    localparam int OUT_CS    = 0;
    localparam int OUT_SK    = 1;
    localparam int OUT_DO    = 2;
    localparam int OUT_DOEN  = 3;
    localparam int OUT_CTLEN = 4;
    localparam int OUT_BUSY  = 5;
    localparam int OUT_DONE  = 6;

    // One input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic        domain;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic        din;
    } ssrm_item_t;

    // One result item
    typedef struct packed {
        logic        cs_pin;
        logic        sk_pin;
        logic        do_pin;
        logic        do_enable;
        logic        ctl_enable;
        logic        busy_res;
        logic        done_res;
        logic [31:0] read_data;
    } ssrm_result_t;

endpackage

@@ design/ssrm_seq.sv @@
// Pin sequencer: state registers and the one-tick next-state and result logic.
`timescale 1ns / 1ps
module ssrm_seq
    import ssrm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  ssrm_item_t   item,
    input  logic [7:0]   half_period,
    output ssrm_result_t result
);

    ssrm_phase_t         phase_reg, phase_next;
    logic [7:0]          tick_reg, tick_next;
    logic [5:0]          bit_reg, bit_next;
    logic [FRAME_W-1:0]  out_shift_reg, out_shift_next;
    logic [31:0]         in_shift_reg, in_shift_next;
    logic                is_write_reg, is_write_next;
    logic [PIN_W-1:0]    pins_reg, pins_next;
    logic                post_sample_reg, post_sample_next;
    logic [31:0]         last_read_reg, last_read_next;
    logic                done;
    logic [7:0]          hp;
    logic [63:0]         frame_ext;
    logic [5:0]          frame_idx;
    logic [5:0]          bit_dec;

    assign hp        = (half_period == 8'd0) ? 8'd1 : half_period;
    assign frame_ext = {{(64 - FRAME_W){1'b0}}, out_shift_reg};
    assign bit_dec   = bit_reg - 6'd1;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_reg        <= 8'd0;
            bit_reg         <= 6'd0;
            out_shift_reg   <= '0;
            in_shift_reg    <= 32'd0;
            is_write_reg    <= 1'b0;
            pins_reg        <= '0;
            post_sample_reg <= 1'b0;
            last_read_reg   <= 32'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            tick_reg        <= tick_next;
            bit_reg         <= bit_next;
            out_shift_reg   <= out_shift_next;
            in_shift_reg    <= in_shift_next;
            is_write_reg    <= is_write_next;
            pins_reg        <= pins_next;
            post_sample_reg <= post_sample_next;
            last_read_reg   <= last_read_next;
        end
    end

    // Next state for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        tick_next        = tick_reg;
        bit_next         = bit_reg;
        out_shift_next   = out_shift_reg;
        in_shift_next    = in_shift_reg;
        is_write_next    = is_write_reg;
        pins_next        = pins_reg;
        post_sample_next = post_sample_reg;
        last_read_next   = last_read_reg;
        done             = 1'b0;
        frame_idx        = bit_dec;

        if (phase_reg == PH_IDLE)
        begin
            // Start a transaction
            if (item.cmd == CMD_READ || item.cmd == CMD_WRITE)
            begin
                is_write_next    = (item.cmd == CMD_WRITE);
                post_sample_next = 1'b0;
                if (item.cmd == CMD_WRITE)
                begin
                    out_shift_next = {{(FRAME_W - 27){1'b0}}, WRITE_OPCODE,
                                      item.reg_addr, item.write_data};
                end
                else
                begin
                    in_shift_next  = 32'd0;
                    out_shift_next = {READ_PREAMBLE, READ_OPCODE, item.domain,
                                      2'b00, item.reg_addr[6:0]};
                end
                phase_next = PH_PREP;
                bit_next   = 6'd1;
                pins_next  = '0;
                pins_next[PIN_CTLEN] = 1'b1;
                pins_next[PIN_DOEN]  = 1'b1;
                tick_next  = 8'd1;
            end
        end
        else if (tick_reg < hp)
        begin
            tick_next = tick_reg + 8'd1;
        end
        else
        begin
            tick_next = 8'd1;
            unique case (phase_reg)
                PH_PREP:
                begin
                    if (bit_reg != 6'd0)
                    begin
                        bit_next = 6'd0;
                        pins_next[PIN_CS] = is_write_reg;
                    end
                    else
                    begin
                        phase_next = PH_SHIFT;
                        bit_next   = is_write_reg ? WRITE_BITS : READ_BITS;
                        frame_idx  = (is_write_reg ? WRITE_BITS : READ_BITS) - 6'd1;
                        pins_next[PIN_SK] = 1'b0;
                        pins_next[PIN_DO] = frame_ext[frame_idx];
                    end
                end
                PH_SHIFT:
                begin
                    if (!pins_reg[PIN_SK])
                    begin
                        pins_next[PIN_SK] = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_dec;
                        pins_next[PIN_SK] = 1'b0;
                        frame_idx = bit_dec - 6'd1;
                        if (bit_dec == 6'd0)
                            phase_next = PH_TRAIL;
                        else
                            pins_next[PIN_DO] = frame_ext[frame_idx];
                    end
                end
                PH_TRAIL:
                begin
                    if (is_write_reg)
                    begin
                        pins_next[PIN_CS] = 1'b0;
                        phase_next = PH_PULSE;
                        bit_next   = EXTRA_CLOCKS;
                        pins_next[PIN_SK] = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RELEASE;
                        pins_next[PIN_DOEN] = 1'b0;
                        pins_next[PIN_DO]   = 1'b0;
                    end
                end
                PH_RELEASE:
                begin
                    phase_next = PH_PULSE;
                    bit_next   = EXTRA_CLOCKS;
                    pins_next[PIN_SK] = 1'b1;
                end
                PH_PULSE:
                begin
                    if (pins_reg[PIN_SK])
                    begin
                        pins_next[PIN_SK] = 1'b0;
                    end
                    else
                    begin
                        bit_next = bit_dec;
                        if (bit_dec != 6'd0)
                        begin
                            pins_next[PIN_SK] = 1'b1;
                        end
                        else if (is_write_reg || post_sample_reg)
                        begin
                            phase_next = PH_CLOSE;
                            pins_next  = '0;
                        end
                        else
                        begin
                            phase_next = PH_SAMPLE;
                            bit_next   = SAMPLE_BITS;
                        end
                    end
                end
                PH_SAMPLE:
                begin
                    if (!pins_reg[PIN_SK])
                    begin
                        if (bit_reg == 6'd0)
                        begin
                            post_sample_next = 1'b1;
                            phase_next = PH_PULSE;
                            bit_next   = EXTRA_CLOCKS;
                        end
                        else
                        begin
                            // Sample din as the clock rises
                            in_shift_next = {in_shift_reg[30:0], item.din};
                        end
                        pins_next[PIN_SK] = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_dec;
                        pins_next[PIN_SK] = 1'b0;
                    end
                end
                PH_CLOSE:
                begin
                    phase_next = PH_IDLE;
                    pins_next  = '0;
                    if (!is_write_reg)
                        last_read_next = in_shift_reg;
                    done = 1'b1;
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                    pins_next  = '0;
                end
            endcase
        end
    end

    // Result for this tick, from the new state
    always_comb
    begin
        result.cs_pin     = pins_next[PIN_CS];
        result.sk_pin     = pins_next[PIN_SK];
        result.do_pin     = pins_next[PIN_DO] & pins_next[PIN_DOEN];
        result.do_enable  = pins_next[PIN_DOEN];
        result.ctl_enable = pins_next[PIN_CTLEN];
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.read_data  = last_read_next;
    end

endmodule

@@ design/serial_switch_register_master.sv @@
// Top level: stream ports, input and result registers, half period register.
// An accepted item is held in the input register, its result item in the result register.
// Throughput: one item per cycle; the input register takes a new item while
// the result register still waits on m_tready (stall reaches s_tready when both hold).
// Each item is one sequencer tick; a clock phase on the pins spans half_period_ticks items.
// Reset: rst_n asynchronous, clears sequencer, pins released, half period back to 3.
`timescale 1ns / 1ps
module serial_switch_register_master
    import ssrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: domain[0], reg_addr[8:1], write_data[24:9], din[25], zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    // m_tdata: cs_pin[0], sk_pin[1], do_pin[2], do_enable[3], ctl_enable[4],
    //          busy_res[5], done_res[6], read_data[38:7], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // Configuration: half_period_ticks
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic         in_valid_reg, in_valid_next;
    ssrm_item_t   in_item_reg;
    logic         out_valid_reg, out_valid_next;
    ssrm_result_t out_res_reg;
    logic [7:0]   half_period_reg;
    logic         step;
    ssrm_result_t seq_res;

    // Handshake
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                half_period_reg <= cfg_data;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd        <= s_tuser;
            in_item_reg.domain     <= s_tdata[0];
            in_item_reg.reg_addr   <= s_tdata[8:1];
            in_item_reg.write_data <= s_tdata[24:9];
            in_item_reg.din        <= s_tdata[25];
        end
    end

    ssrm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .half_period (half_period_reg),
        .result      (seq_res)
    );

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= seq_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.read_data, out_res_reg.done_res,
                       out_res_reg.busy_res, out_res_reg.ctl_enable,
                       out_res_reg.do_enable, out_res_reg.do_pin,
                       out_res_reg.sk_pin, out_res_reg.cs_pin};

    // A finished transaction is no longer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_DONE] |-> !m_tdata[OUT_BUSY])
        else $error("done with busy still set");

    // Data level only shows while driven
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_DO] |-> m_tdata[OUT_DOEN])
        else $error("data level without data enable");

    // Data pin is driven only while select and clock are driven
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_DOEN] |-> m_tdata[OUT_CTLEN] && m_tdata[OUT_BUSY])
        else $error("data enable outside a transaction");

    // A processed item always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost");

endmodule
